[sv/srtp_pkg.sv]
// Shared types, constants and AES functions for the SRTP counter-mode cipher.
package srtp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned OutDepth   = 4;
  localparam int unsigned Rounds     = 10;
  localparam int unsigned CfgWidth   = 64;
  localparam int unsigned CfgIdxW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH  = 2'd0,
    REG_KEY_LOW   = 2'd1,
    REG_SALT_HIGH = 2'd2,
    REG_SALT_LOW  = 2'd3
  } cfg_reg_t;

  // One classified item on its way to the cipher pipeline.
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] key;
    logic [3:0]   pos;
    logic [7:0]   data;
    logic         last;
  } item_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    unique case (rnd)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Next round key from the previous one.
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp, n0, n1, n2, n3;
    w0  = rk[127:96];
    w1  = rk[95:64];
    w2  = rk[63:32];
    w3  = rk[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0  = w0 ^ tmp;
    n1  = w1 ^ n0;
    n2  = w2 ^ n1;
    n3  = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // One AES round: SubBytes, ShiftRows, MixColumns (skipped on the final round), AddRoundKey.
  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int j = 0; j < 4; j++) t[c*4+j] = SBOX[s[((c+j)&3)*4+j]];
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4];
        a1 = t[c*4+1];
        a2 = t[c*4+2];
        a3 = t[c*4+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = t[i] ^ rk[127-8*i -: 8];
    return res;
  endfunction

endpackage

[sv/srtp_fifo.sv]
// Small synchronous queue with registered storage.
module srtp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_r, rd_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == PtrW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == PtrW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= wdata;
  end
endmodule

[sv/srtp_front.sv]
// Front end: configuration registers, counter tracking and item classification.
module srtp_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [srtp_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [srtp_pkg::CfgWidth-1:0]   cfg_data,
  input  logic                            accept,
  input  logic                            first_byte,
  input  logic [47:0]                     packet_index,
  input  logic [31:0]                     source_id,
  input  logic [7:0]                      data_byte,
  input  logic                            last_byte,
  output srtp_pkg::item_t                 item
);
  logic [63:0]  key_hi_r, key_lo_r, salt_lo_r;
  logic [47:0]  salt_hi_r;
  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] ks_ctr_r, ks_ctr_nxt;
  logic [127:0] ks_key_r, ks_key_nxt;
  logic [3:0]   pos_r, pos_nxt, pos_use;
  logic [127:0] built, use_ctr;
  logic         fetch;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r  <= '0;
      key_lo_r  <= '0;
      salt_hi_r <= '0;
      salt_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (srtp_pkg::cfg_reg_t'(cfg_index))
        srtp_pkg::REG_KEY_HIGH:  key_hi_r  <= cfg_data;
        srtp_pkg::REG_KEY_LOW:   key_lo_r  <= cfg_data;
        srtp_pkg::REG_SALT_HIGH: salt_hi_r <= cfg_data[47:0];
        srtp_pkg::REG_SALT_LOW:  salt_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    built[127:64] = {salt_hi_r, 16'h0000} ^ {48'h0, salt_lo_r[63:48]} ^ {32'h0, source_id};
    built[63:0]   = {salt_lo_r[47:0], 16'h0000} ^ {packet_index, 16'h0000};
    pos_use = first_byte ? 4'd0 : pos_r;
    fetch   = (pos_use == 4'd0);
    use_ctr = first_byte ? built : ctr_r;
    ctr_nxt    = ctr_r;
    ks_ctr_nxt = ks_ctr_r;
    ks_key_nxt = ks_key_r;
    if (fetch) begin
      ctr_nxt    = use_ctr + 128'd1;
      ks_ctr_nxt = use_ctr;
      ks_key_nxt = {key_hi_r, key_lo_r};
    end
    pos_nxt = last_byte ? 4'd0 : pos_use + 4'd1;
    item.ctr  = ks_ctr_nxt;
    item.key  = ks_key_nxt;
    item.pos  = pos_use;
    item.data = data_byte;
    item.last = last_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= '0;
      pos_r <= '0;
    end else if (accept) begin
      ctr_r <= ctr_nxt;
      pos_r <= pos_nxt;
    end
  end

  // The block keystream state is always loaded before it is used.
  always_ff @(posedge clk) begin
    if (accept) begin
      ks_ctr_r <= ks_ctr_nxt;
      ks_key_r <= ks_key_nxt;
    end
  end
endmodule

[sv/srtp_aes_pipe.sv]
// Back end: fully pipelined AES-128 with on-the-fly key schedule and keystream XOR.
module srtp_aes_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  srtp_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            out_full,
  output logic            out_push,
  output logic [8:0]      out_data
);
  localparam int unsigned NR = srtp_pkg::Rounds;

  logic         vld_r  [NR+1];
  logic [127:0] st_r   [NR+1];
  logic [127:0] rk_r   [NR+1];
  logic [3:0]   pos_r  [NR+1];
  logic [7:0]   dat_r  [NR+1];
  logic         last_r [NR+1];
  logic         adv;
  logic [127:0] ks_shift;

  // The whole pipeline moves together whenever the result queue has room.
  assign adv   = !out_full;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]   <= q_item.ctr ^ q_item.key;
      rk_r[0]   <= q_item.key;
      pos_r[0]  <= q_item.pos;
      dat_r[0]  <= q_item.data;
      last_r[0] <= q_item.last;
    end
  end

  for (genvar g = 1; g <= NR; g++) begin : g_round
    logic [127:0] rk_nxt;
    assign rk_nxt = srtp_pkg::key_next(rk_r[g-1], srtp_pkg::rcon(4'(g)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (adv) begin
        vld_r[g] <= vld_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[g]   <= srtp_pkg::aes_round(st_r[g-1], rk_nxt, g == NR);
        rk_r[g]   <= rk_nxt;
        pos_r[g]  <= pos_r[g-1];
        dat_r[g]  <= dat_r[g-1];
        last_r[g] <= last_r[g-1];
      end
    end
  end

  assign ks_shift = st_r[NR] >> {~pos_r[NR], 3'b000};
  assign out_push = adv && vld_r[NR];
  assign out_data = {last_r[NR], dat_r[NR] ^ ks_shift[7:0]};
endmodule

[sv/srtp_aes_counter_mode_crypt.sv]
// Top level of the SRTP AES-128 counter-mode payload cipher.
//
// This block encrypts or decrypts an SRTP/SRTCP payload one byte per item; the
// same operation serves both directions. An item with first_byte set builds a
// fresh 128-bit counter from the session salt, the SSRC and the 48-bit packet
// index; every 16 bytes (or fewer, when last_byte ends a packet early) use the
// AES-128 encryption of one counter value under the session key, and the counter
// then steps by one modulo 2^128. Both sides behave as queues: push an item while
// full is low, pop a result while empty is low. The block takes one item per
// clock cycle and delivers one result per cycle when the consumer keeps popping.
// Every item runs through an 11-stage AES pipeline (initial key add plus ten
// rounds, the round keys computed alongside): the input queue hands the item
// to the first stage, it crosses the eleven stages, and the result queue shows
// it after the last stage; a full result queue stalls the pipeline. The key
// and salt registers must be written by the user through the cfg port while
// no item is in flight; the block does not enforce this. A new key applies
// from the next keystream block and a new salt from the next packet start.
module srtp_aes_counter_mode_crypt #(
  parameter int unsigned QUEUE_DEPTH = srtp_pkg::QueueDepth,
  parameter int unsigned OUT_DEPTH   = srtp_pkg::OutDepth
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [srtp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [srtp_pkg::CfgWidth-1:0] cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_first_byte,
  input  logic [47:0]                   in_packet_index,
  input  logic [31:0]                   in_source_id,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_byte,
  output logic                          out_last
);
  srtp_pkg::item_t front_item, q_item;
  logic            accept, q_empty, q_pop;
  logic            res_full, res_push;
  logic [8:0]      res_data, res_head;

  assign accept = in_push && !in_full;

  // Front end tracks the counter and byte position of each packet.
  srtp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .first_byte   (in_first_byte),
    .packet_index (in_packet_index),
    .source_id    (in_source_id),
    .data_byte    (in_data_byte),
    .last_byte    (in_last_byte),
    .item         (front_item)
  );

  // Queue between classification and the cipher pipeline.
  srtp_fifo #(
    .WIDTH ($bits(srtp_pkg::item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  srtp_aes_pipe u_aes (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_full (res_full),
    .out_push (res_push),
    .out_data (res_data)
  );

  // Result queue decouples the pipeline from the consumer.
  srtp_fifo #(
    .WIDTH (9),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_byte = res_head[7:0];
  assign out_last = res_head[8];
endmodule

[sv/srtp_checker.sv]
// Port-level checks for the SRTP counter-mode cipher, bound to the top level.
module srtp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_last
);
  // After reset the result queue is empty and the input queue is not full.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // No item can have crossed the cipher pipeline when this check samples after reset.
  a_min_latency: assert property (@(posedge clk) $past(!rst_n, 3) |-> out_empty)
    else $error("result appeared too soon after reset");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_byte) && $stable(out_last))
    else $error("waiting result changed");

  // Input queue cannot be full right after reset is released.
  a_full_late: assert property (@(posedge clk) $past(!rst_n, 2) |-> !in_full)
    else $error("input full too soon after reset");
endmodule

bind srtp_aes_counter_mode_crypt srtp_checker u_srtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_byte  (out_byte),
  .out_last  (out_last)
);
